// ===== rtl/ifl_pkg.sv =====
// ----------------------------------------------------------------------------
// ifl_pkg
// Shared types and constants for the interleaved free-list builder.
// ----------------------------------------------------------------------------
package ifl_pkg;

  localparam int unsigned CHUNK_SLOTS    = 64;
  localparam int unsigned MAX_INTERLEAVE = 32;

  localparam int unsigned BLK_W   = 32;
  localparam int unsigned FACT_W  = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned STEP_W  = 6;

  localparam logic [STEP_W-1:0] DIV_LONG_STEPS  = STEP_W'(BLK_W);
  localparam logic [STEP_W-1:0] DIV_SHORT_STEPS = STEP_W'(FACT_W);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVE_M   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVE_N   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FS_BLOCK_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FREE     = 3'd4;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_SCAN  = 1'b1;

  typedef enum logic [2:0] {
    KIND_STORED  = 3'd0,
    KIND_CLOSED  = 3'd1,
    KIND_OPENED  = 3'd2,
    KIND_ENDED   = 3'd3,
    KIND_NO_ROOM = 3'd4
  } kind_t;

  // divider request / response
  typedef struct packed {
    logic              start;
    logic              short_op;   // 6-bit dividend, 6 steps
    logic [BLK_W-1:0]  dividend;
    logic [FACT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [BLK_W-1:0]  quot;
    logic [FACT_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/ifl_divider.sv =====
// ----------------------------------------------------------------------------
// ifl_divider
// Restoring radix-2 divider, 32-bit or 6-bit dividend by 6-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ifl_divider
  import ifl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [BLK_W-1:0]  acc_r, acc_nxt;
  logic [FACT_W-1:0] rem_r, rem_nxt;
  logic [FACT_W-1:0] dsr_r, dsr_nxt;
  logic [FACT_W:0]   trial;
  logic              qbit;

  assign trial = {rem_r, acc_r[BLK_W-1]};
  assign qbit  = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      if (req.short_op) begin
        // park the narrow dividend at the top so the low bits end up clean
        acc_nxt = {req.dividend[FACT_W-1:0], {(BLK_W-FACT_W){1'b0}}};
        cnt_nxt = DIV_SHORT_STEPS;
      end else begin
        acc_nxt = req.dividend;
        cnt_nxt = DIV_LONG_STEPS;
      end
    end else if (busy_r) begin
      rem_nxt = qbit ? FACT_W'(trial - {1'b0, dsr_r}) : trial[FACT_W-1:0];
      acc_nxt = {acc_r[BLK_W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = acc_r;
  assign rsp.rem  = rem_r;

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

  a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dsr_r))
    else $error("divider remainder not below divisor");
`endif

endmodule

// ===== rtl/interleaved_free_list_builder.sv =====
// A start word runs a 6-step factor check, two 32-step window divisions and a chunk
//   open; a free scan word in the window runs a 32-step block mod n and a 6-step split,
//   one outside it goes straight to the store. Ignored words are simply dropped.
// Input is ready the cycle after the last result is loaded; a word that closes a chunk
//   gives three results, one per cycle at best. The serial divider sets the rate.
// Reset (synchronous, rst_n low): config registers m=n=1, others 0; list finished.
// ----------------------------------------------------------------------------
// interleaved_free_list_builder
// Sequencer around one serial divider that rebuilds a chained free list.
// ----------------------------------------------------------------------------
module interleaved_free_list_builder
  import ifl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BLK_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [BLK_W-1:0]     in_scan_block,
  input  logic                 in_block_in_use,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_kind,
  output logic [BLK_W-1:0]     out_list_block,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [BLK_W-1:0]     out_value,
  output logic [CNT_W-1:0]     out_count,
  output logic                 out_last
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_RATIO = 11'b00000000010,
    ST_LOW   = 11'b00000000100,
    ST_HIGH  = 11'b00000001000,
    ST_OPEN  = 11'b00000010000,
    ST_WIN   = 11'b00000100000,
    ST_MOD   = 11'b00001000000,
    ST_PERM  = 11'b00010000000,
    ST_PUT   = 11'b00100000000,
    ST_CLOSE = 11'b01000000000,
    ST_NEXT  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [FACT_W-1:0] cfg_m_r, cfg_n_r;
  logic [BLK_W-1:0]  cfg_fdb_r, cfg_fbc_r, cfg_total_r;

  // build state
  logic [FACT_W-1:0] eff_m_r, eff_m_nxt, eff_n_r, eff_n_nxt, ratio_r, ratio_nxt;
  logic [BLK_W-1:0]  map_low_r, map_low_nxt, map_high_r, map_high_nxt;
  logic [BLK_W-1:0]  remaining_r, remaining_nxt, cur_list_r, cur_list_nxt;
  logic [CNT_W-1:0]  slot_ptr_r, slot_ptr_nxt, chunk_cnt_r, chunk_cnt_nxt;
  logic              finished_r, finished_nxt;
  logic [BLK_W-1:0]  blk_r, blk_nxt, mapped_r, mapped_nxt;
  logic [FACT_W-1:0] idx_r, idx_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  kind_t             o_kind_r, o_kind_nxt;
  logic [BLK_W-1:0]  o_lb_r, o_lb_nxt, o_value_r, o_value_nxt;
  logic [SLOT_W-1:0] o_slot_r, o_slot_nxt;
  logic [CNT_W-1:0]  o_count_r, o_count_nxt;
  logic              o_last_r, o_last_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              slot_free, ld, in_acc, bad_fact, in_win;
  logic [FACT_W-1:0] sel_n;
  logic [BLK_W:0]    lo_ext;
  logic [FACT_W-1:0] lo_add;
  logic [CNT_W-1:0]  num;
  logic [2*FACT_W-1:0] prod;
  logic [BLK_W-1:0]  off;
  logic [CNT_W-1:0]  sp_dec;

  ifl_divider u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign bad_fact = (cfg_m_r == '0) || (cfg_n_r > FACT_W'(MAX_INTERLEAVE)) ||
                    (cfg_m_r > cfg_n_r) || (div_rsp.rem != '0);
  assign sel_n    = bad_fact ? FACT_W'(1) : cfg_n_r;

  // ceil to a multiple of n: add n - r when not already aligned
  assign lo_add = (div_rsp.rem != '0) ? (eff_n_r - div_rsp.rem) : '0;
  assign lo_ext = {1'b0, cfg_fdb_r} + {{(BLK_W-FACT_W+1){1'b0}}, lo_add};

  assign num = (remaining_r < BLK_W'(CHUNK_SLOTS)) ? remaining_r[CNT_W-1:0]
                                                   : CNT_W'(CHUNK_SLOTS);

  assign in_win = (blk_r >= map_low_r) && (blk_r < map_high_r);
  assign prod   = div_rsp.rem * eff_m_r;
  assign off    = BLK_W'(div_rsp.quot[FACT_W-1:0]) + BLK_W'(prod);
  assign sp_dec = slot_ptr_r - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    eff_m_nxt     = eff_m_r;
    eff_n_nxt     = eff_n_r;
    ratio_nxt     = ratio_r;
    map_low_nxt   = map_low_r;
    map_high_nxt  = map_high_r;
    remaining_nxt = remaining_r;
    cur_list_nxt  = cur_list_r;
    slot_ptr_nxt  = slot_ptr_r;
    chunk_cnt_nxt = chunk_cnt_r;
    finished_nxt  = finished_r;
    blk_nxt       = blk_r;
    mapped_nxt    = mapped_r;
    idx_nxt       = idx_r;

    div_req          = '0;
    ld               = 1'b0;
    o_kind_nxt       = o_kind_r;
    o_lb_nxt         = o_lb_r;
    o_slot_nxt       = o_slot_r;
    o_value_nxt      = o_value_r;
    o_count_nxt      = o_count_r;
    o_last_nxt       = o_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          blk_nxt = in_scan_block;
          if (in_action == ACT_START) begin
            // factor check: n / m, m forced nonzero for the divide
            div_req.start    = 1'b1;
            div_req.short_op = 1'b1;
            div_req.dividend = BLK_W'(cfg_n_r);
            div_req.divisor  = (cfg_m_r == '0) ? FACT_W'(1) : cfg_m_r;
            state_nxt        = ST_RATIO;
          end else if (!finished_r && !in_block_in_use) begin
            state_nxt = ST_WIN;
          end
        end
      end
      ST_RATIO: begin
        if (div_rsp.done) begin
          eff_m_nxt = bad_fact ? FACT_W'(1) : cfg_m_r;
          eff_n_nxt = sel_n;
          ratio_nxt = bad_fact ? FACT_W'(1) : div_rsp.quot[FACT_W-1:0];
          div_req.start    = 1'b1;
          div_req.dividend = cfg_fdb_r;
          div_req.divisor  = sel_n;
          state_nxt        = ST_LOW;
        end
      end
      ST_LOW: begin
        if (div_rsp.done) begin
          map_low_nxt      = lo_ext[BLK_W] ? '1 : lo_ext[BLK_W-1:0];
          div_req.start    = 1'b1;
          div_req.dividend = cfg_fbc_r;
          div_req.divisor  = eff_n_r;
          state_nxt        = ST_HIGH;
        end
      end
      ST_HIGH: begin
        if (div_rsp.done) begin
          map_high_nxt  = cfg_fbc_r - BLK_W'(div_rsp.rem);
          remaining_nxt = cfg_total_r;
          cur_list_nxt  = '0;
          finished_nxt  = 1'b0;
          state_nxt     = ST_OPEN;
        end
      end
      ST_OPEN: begin
        if (slot_free) begin
          remaining_nxt = remaining_r - BLK_W'(num);
          slot_ptr_nxt  = num;
          chunk_cnt_nxt = num;
          ld            = 1'b1;
          o_kind_nxt    = KIND_OPENED;
          o_lb_nxt      = '0;
          o_slot_nxt    = '0;
          o_value_nxt   = '0;
          o_count_nxt   = num;
          o_last_nxt    = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_WIN: begin
        if (in_win) begin
          div_req.start    = 1'b1;
          div_req.dividend = blk_r;
          div_req.divisor  = eff_n_r;
          state_nxt        = ST_MOD;
        end else begin
          mapped_nxt = blk_r;
          state_nxt  = ST_PUT;
        end
      end
      ST_MOD: begin
        if (div_rsp.done) begin
          idx_nxt          = div_rsp.rem;
          div_req.start    = 1'b1;
          div_req.short_op = 1'b1;
          div_req.dividend = BLK_W'(div_rsp.rem);
          div_req.divisor  = ratio_r;
          state_nxt        = ST_PERM;
        end
      end
      ST_PERM: begin
        if (div_rsp.done) begin
          mapped_nxt = blk_r - BLK_W'(idx_r) + off;
          state_nxt  = ST_PUT;
        end
      end
      ST_PUT: begin
        if (slot_free) begin
          ld          = 1'b1;
          o_lb_nxt    = cur_list_r;
          o_value_nxt = mapped_r;
          o_count_nxt = '0;
          o_slot_nxt  = '0;
          if (slot_ptr_r == '0) begin
            o_kind_nxt = KIND_NO_ROOM;
            o_last_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            slot_ptr_nxt = sp_dec;
            o_kind_nxt   = KIND_STORED;
            o_slot_nxt   = sp_dec[SLOT_W-1:0];
            if (sp_dec != '0) begin
              o_last_nxt = 1'b1;
              state_nxt  = ST_IDLE;
            end else begin
              o_last_nxt = 1'b0;
              state_nxt  = ST_CLOSE;
            end
          end
        end
      end
      ST_CLOSE: begin
        if (slot_free) begin
          ld          = 1'b1;
          o_kind_nxt  = KIND_CLOSED;
          o_lb_nxt    = cur_list_r;
          o_slot_nxt  = '0;
          o_value_nxt = mapped_r;
          o_count_nxt = chunk_cnt_r;
          o_last_nxt  = 1'b0;
          state_nxt   = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (slot_free) begin
          ld          = 1'b1;
          o_lb_nxt    = mapped_r;
          o_slot_nxt  = '0;
          o_value_nxt = mapped_r;
          o_last_nxt  = 1'b1;
          state_nxt   = ST_IDLE;
          if (remaining_r == '0) begin
            finished_nxt = 1'b1;
            o_kind_nxt   = KIND_ENDED;
            o_count_nxt  = '0;
          end else begin
            // the stored block becomes the next chunk holder
            cur_list_nxt  = mapped_r;
            remaining_nxt = remaining_r - BLK_W'(num);
            slot_ptr_nxt  = num;
            chunk_cnt_nxt = num;
            o_kind_nxt    = KIND_OPENED;
            o_count_nxt   = num;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_m_r     <= FACT_W'(1);
      cfg_n_r     <= FACT_W'(1);
      cfg_fdb_r   <= '0;
      cfg_fbc_r   <= '0;
      cfg_total_r <= '0;
      eff_m_r     <= FACT_W'(1);
      eff_n_r     <= FACT_W'(1);
      ratio_r     <= FACT_W'(1);
      map_low_r   <= '0;
      map_high_r  <= '0;
      remaining_r <= '0;
      cur_list_r  <= '0;
      slot_ptr_r  <= '0;
      chunk_cnt_r <= '0;
      finished_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      eff_m_r     <= eff_m_nxt;
      eff_n_r     <= eff_n_nxt;
      ratio_r     <= ratio_nxt;
      map_low_r   <= map_low_nxt;
      map_high_r  <= map_high_nxt;
      remaining_r <= remaining_nxt;
      cur_list_r  <= cur_list_nxt;
      slot_ptr_r  <= slot_ptr_nxt;
      chunk_cnt_r <= chunk_cnt_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_INTERLEAVE_M:   cfg_m_r     <= cfg_data[FACT_W-1:0];
          CFG_INTERLEAVE_N:   cfg_n_r     <= cfg_data[FACT_W-1:0];
          CFG_FIRST_DATA_BLK: cfg_fdb_r   <= cfg_data;
          CFG_FS_BLOCK_COUNT: cfg_fbc_r   <= cfg_data;
          CFG_TOTAL_FREE:     cfg_total_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    blk_r     <= blk_nxt;
    mapped_r  <= mapped_nxt;
    idx_r     <= idx_nxt;
    o_kind_r  <= o_kind_nxt;
    o_lb_r    <= o_lb_nxt;
    o_slot_r  <= o_slot_nxt;
    o_value_r <= o_value_nxt;
    o_count_r <= o_count_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = o_kind_r;
  assign out_list_block = o_lb_r;
  assign out_slot       = o_slot_r;
  assign out_value      = o_value_r;
  assign out_count      = o_count_r;
  assign out_last       = o_last_r;

`ifndef ASSERT_OFF
  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_rsp.busy)
    else $error("input ready while divider still busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_RATIO || state_r == ST_LOW ||
                      state_r == ST_HIGH || state_r == ST_MOD ||
                      state_r == ST_PERM))
    else $error("divider result with no state waiting for it");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_ptr_r <= chunk_cnt_r)
    else $error("slot pointer above chunk count");

  a_no_room_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && o_kind_nxt == KIND_NO_ROOM) |-> (slot_ptr_r == '0))
    else $error("no-room word while a slot is left");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !ld)
    else $error("output register overwritten before taken");
`endif

endmodule
